@@ design/pat2_pkg.sv @@
`default_nettype none

package pat2_pkg;

   // Internal fixed-point scale of the polynomial evaluation.
   localparam int QI      = 30;
   localparam int ANGLE_W = 16;

   // Coefficients and base angles in Q.30.
   localparam logic [31:0] C3_Q   = 32'd195528386;
   localparam logic [31:0] C1_Q   = 32'd1038845215;
   localparam logic [31:0] PI4_Q  = 32'd843314842;
   localparam logic [31:0] PI34_Q = 32'd2529944526;
   localparam logic [31:0] PI_Q   = 32'd3373259369;

   typedef struct packed {
      logic y_neg;     // result is negated at the end
      logic base_hi;   // base angle is 3pi/4 instead of pi/4
      logic r_neg;     // sign of the ratio
      logic den_zero;  // both inputs zero, ratio forced to -1
   } pat2_side_type;

endpackage

`default_nettype wire

@@ design/polynomial_atan2_core.sv @@
`default_nettype none

// Four-quadrant arctangent of a signed (y, x) beat by the cubic polynomial
// approximation. The result is the angle in radians, signed Q3.ANGLE_FRAC_BITS,
// saturated at plus or minus pi; x = y = 0 gives pi/2. One beat is accepted per
// clock cycle while no stall reaches back to the input, and one result leaves for
// each, in order. The pipeline is one input stage, a row of RATIO_FRAC_BITS + 1
// divider cells that each settle one quotient bit of the ratio, and five
// polynomial stages ending in the output register. Every stage holds its beat
// when the one after it is stalled, so bubbles collapse and the input keeps
// accepting while a finished result waits, as long as some stage is empty.
module polynomial_atan2_core #(
   parameter int INPUT_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int RATIO_FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // y_coord, x_coord, zero fill to whole bytes
   input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // angle
   output logic [pat2_pkg::ANGLE_W-1:0]           rsp_tdata
);
   import pat2_pkg::*;

   localparam int IW    = INPUT_WIDTH;
   localparam int DEN_W = IW + 1;
   localparam int LOW_W = RATIO_FRAC_BITS + 1;
   localparam int DIV_W = IW + 1 + RATIO_FRAC_BITS;
   localparam int EXT_W = IW + 2;

   // Input stage: magnitudes, ratio numerator and denominator, dividend split.
   logic signed [IW-1:0]    y_coord;
   logic signed [IW-1:0]    x_coord;
   logic signed [EXT_W-1:0] y_ext;
   logic signed [EXT_W-1:0] x_ext;
   logic signed [EXT_W-1:0] ay_ext;
   logic signed [EXT_W-1:0] num;
   logic signed [EXT_W-1:0] den;
   logic [EXT_W-1:0]        nabs;
   logic [DEN_W-1:0]        nmag;
   logic [DIV_W-1:0]        dividend;

   logic                    prep_valid_ff;
   logic [DEN_W-1:0]        prep_rem_ff, prep_rem_in;
   logic [LOW_W-1:0]        prep_low_ff, prep_low_in;
   logic [DEN_W-1:0]        prep_den_ff, prep_den_in;
   pat2_side_type           prep_side_ff, prep_side_in;
   logic                    prep_advance;

   always_comb begin
      y_coord = req_tdata[IW-1:0];
      x_coord = req_tdata[2*IW-1:IW];
      y_ext   = EXT_W'(y_coord);
      x_ext   = EXT_W'(x_coord);
      ay_ext  = y_coord[IW-1] ? -y_ext : y_ext;
      if (!x_coord[IW-1]) begin
         num = x_ext - ay_ext;
         den = x_ext + ay_ext;
      end else begin
         num = x_ext + ay_ext;
         den = ay_ext - x_ext;
      end
      nabs     = num[EXT_W-1] ? EXT_W'(-num) : EXT_W'(num);
      nmag     = nabs[DEN_W-1:0];
      prep_den_in = den[DEN_W-1:0];
      // Rounded ratio: (|num| * 2^R + den/2) / den, the quotient never above 2^R.
      dividend = {nmag, {RATIO_FRAC_BITS{1'b0}}} + DIV_W'(prep_den_in >> 1);
      prep_rem_in = DEN_W'(dividend[DIV_W-1:LOW_W]);
      prep_low_in = dividend[LOW_W-1:0];
      prep_side_in.y_neg    = y_coord[IW-1];
      prep_side_in.base_hi  = x_coord[IW-1];
      prep_side_in.r_neg    = num[EXT_W-1];
      prep_side_in.den_zero = (prep_den_in == '0);
   end

   logic                 chain_valid [0:LOW_W];
   logic                 chain_ready [0:LOW_W];
   logic [DEN_W-1:0]     chain_rem   [0:LOW_W];
   logic [LOW_W-1:0]     chain_low   [0:LOW_W];
   logic [LOW_W-1:0]     chain_quot  [0:LOW_W];
   logic [DEN_W-1:0]     chain_den   [0:LOW_W];
   pat2_side_type        chain_side  [0:LOW_W];

   assign prep_advance = !prep_valid_ff || chain_ready[0];
   assign req_tready   = prep_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_advance) begin
         prep_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_advance && req_tvalid) begin
         prep_rem_ff  <= prep_rem_in;
         prep_low_ff  <= prep_low_in;
         prep_den_ff  <= prep_den_in;
         prep_side_ff <= prep_side_in;
      end
   end

   assign chain_valid[0] = prep_valid_ff;
   assign chain_rem[0]   = prep_rem_ff;
   assign chain_low[0]   = prep_low_ff;
   assign chain_quot[0]  = '0;
   assign chain_den[0]   = prep_den_ff;
   assign chain_side[0]  = prep_side_ff;

   for (genvar i = 0; i < LOW_W; i++) begin : g_div
      pat2_div_cell #(
         .DEN_W (DEN_W),
         .LOW_W (LOW_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_rem     (chain_rem[i]),
         .up_low     (chain_low[i]),
         .up_quot    (chain_quot[i]),
         .up_den     (chain_den[i]),
         .up_side    (chain_side[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_rem   (chain_rem[i+1]),
         .down_low   (chain_low[i+1]),
         .down_quot  (chain_quot[i+1]),
         .down_den   (chain_den[i+1]),
         .down_side  (chain_side[i+1])
      );
   end

   pat2_poly #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[LOW_W]),
      .in_ready  (chain_ready[LOW_W]),
      .in_mag    (chain_quot[LOW_W]),
      .in_side   (chain_side[LOW_W]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_angle (rsp_tdata)
   );

   // Both inputs zero leaves nothing to divide.
   a_zero_den_empty: assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff && prep_side_ff.den_zero |-> (prep_rem_ff == '0) && (prep_low_ff == '0))
      else $error("zero denominator with nonzero dividend");

   a_first_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff && !prep_side_ff.den_zero |-> prep_rem_ff < prep_den_ff)
      else $error("quotient would exceed the ratio range");

endmodule

`default_nettype wire

@@ design/pat2_div_cell.sv @@
`default_nettype none

module pat2_div_cell #(
   parameter int DEN_W = 17,
   parameter int LOW_W = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [DEN_W-1:0]      up_rem,
   input  logic [LOW_W-1:0]      up_low,
   input  logic [LOW_W-1:0]      up_quot,
   input  logic [DEN_W-1:0]      up_den,
   input  pat2_pkg::pat2_side_type up_side,
   output logic                  down_valid,
   input  logic                  down_ready,
   output logic [DEN_W-1:0]      down_rem,
   output logic [LOW_W-1:0]      down_low,
   output logic [LOW_W-1:0]      down_quot,
   output logic [DEN_W-1:0]      down_den,
   output pat2_pkg::pat2_side_type down_side
);
   import pat2_pkg::*;

   logic                 valid_ff;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [LOW_W-1:0]     low_ff, low_in;
   logic [LOW_W-1:0]     quot_ff, quot_in;
   logic [DEN_W-1:0]     den_ff;
   pat2_side_type        side_ff;
   logic                 advance;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 take;

   assign advance  = !valid_ff || down_ready;
   assign up_ready = advance;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial   = {up_rem, up_low[LOW_W-1]};
      diff    = trial - {1'b0, up_den};
      take    = trial >= {1'b0, up_den};
      rem_in  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_in  = {up_low[LOW_W-2:0], 1'b0};
      quot_in = {up_quot[LOW_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quot_ff <= quot_in;
         den_ff  <= up_den;
         side_ff <= up_side;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_low   = low_ff;
   assign down_quot  = quot_ff;
   assign down_den   = den_ff;
   assign down_side  = side_ff;

   // The partial remainder stays below the divisor whenever the divisor is nonzero.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (den_ff != '0) |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

@@ design/pat2_poly.sv @@
`default_nettype none

module pat2_poly #(
   parameter int RATIO_FRAC_BITS = 14,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [RATIO_FRAC_BITS:0]       in_mag,
   input  pat2_pkg::pat2_side_type        in_side,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [pat2_pkg::ANGLE_W-1:0]   out_angle
);
   import pat2_pkg::*;

   localparam int MAG_W   = RATIO_FRAC_BITS + 1;
   localparam int SHIFT_R = QI - RATIO_FRAC_BITS;
   localparam int R30_W   = QI + 1;
   localparam int SQ_W    = 2 * R30_W;
   localparam int C3_W    = 28;
   localparam int P_W     = C3_W + R30_W;
   localparam int T_W     = QI;
   localparam int PROD_W  = T_W + R30_W;
   localparam int M_W     = 32;
   localparam int A_W     = 34;
   localparam int ROUND_S = QI - ANGLE_FRAC_BITS;
   localparam logic [63:0] HALF_Q  = 64'd1 << (QI - 1);
   localparam logic [63:0] HALF_A  = 64'd1 << (ROUND_S - 1);
   localparam logic [A_W-1:0] PI_OUT =
      A_W'((64'(PI_Q) + HALF_A) >> ROUND_S);

   logic adv1, adv2, adv3, adv4, adv5;

   // Stage 1: ratio magnitude to Q.30 and its square.
   logic                 s1_valid_ff;
   logic [MAG_W-1:0]     rmag;
   logic [R30_W-1:0]     s1_r30_ff, s1_r30_in;
   logic [SQ_W-1:0]      s1_sq_ff, s1_sq_in;
   logic                 s1_rneg_ff, s1_rneg_in;
   pat2_side_type        s1_side_ff;

   always_comb begin
      rmag       = in_side.den_zero ? {1'b1, {RATIO_FRAC_BITS{1'b0}}} : in_mag;
      s1_r30_in  = R30_W'(rmag) << SHIFT_R;
      s1_sq_in   = s1_r30_in * s1_r30_in;
      s1_rneg_in = in_side.den_zero | in_side.r_neg;
   end

   // Stage 2: round the square, multiply by the cubic coefficient.
   logic                 s2_valid_ff;
   logic [R30_W-1:0]     r2;
   logic [P_W-1:0]       s2_p_ff, s2_p_in;
   logic [R30_W-1:0]     s2_r30_ff;
   logic                 s2_rneg_ff;
   pat2_side_type        s2_side_ff;

   always_comb begin
      r2      = R30_W'((s1_sq_ff + SQ_W'(HALF_Q)) >> QI);
      s2_p_in = C3_Q[C3_W-1:0] * r2;
   end

   // Stage 3: the bracket is always negative, so carry its magnitude.
   logic                 s3_valid_ff;
   logic [T_W-1:0]       rp;
   logic [T_W-1:0]       tmag;
   logic [PROD_W-1:0]    s3_prod_ff, s3_prod_in;
   logic                 s3_rneg_ff;
   pat2_side_type        s3_side_ff;

   always_comb begin
      rp         = T_W'((s2_p_ff + P_W'(HALF_Q)) >> QI);
      tmag       = C1_Q[T_W-1:0] - rp;
      s3_prod_in = tmag * s2_r30_ff;
   end

   // Stage 4: add to the base angle and apply the sign of y.
   logic                 s4_valid_ff;
   logic [M_W-1:0]       mterm;
   logic signed [A_W-1:0] base;
   logic signed [A_W-1:0] sum;
   logic signed [A_W-1:0] s4_a_ff, s4_a_in;

   always_comb begin
      mterm   = M_W'((s3_prod_ff + PROD_W'(HALF_Q)) >> QI);
      base    = s3_side_ff.base_hi ? $signed(A_W'(PI34_Q)) : $signed(A_W'(PI4_Q));
      // The product term is -sign(r) times its magnitude.
      sum     = s3_rneg_ff ? base + $signed(A_W'(mterm)) : base - $signed(A_W'(mterm));
      s4_a_in = s3_side_ff.y_neg ? -sum : sum;
   end

   // Stage 5: round to the output scale and saturate at pi.
   logic                 out_valid_ff;
   logic                 a_neg;
   logic [A_W-1:0]       amag;
   logic [A_W-1:0]       arnd;
   logic [A_W-1:0]       asat;
   logic [A_W-1:0]       asig;
   logic [ANGLE_W-1:0]   out_angle_ff, out_angle_in;

   always_comb begin
      a_neg        = s4_a_ff[A_W-1];
      amag         = a_neg ? A_W'(-s4_a_ff) : A_W'(s4_a_ff);
      arnd         = A_W'((amag + A_W'(HALF_A)) >> ROUND_S);
      asat         = (arnd > PI_OUT) ? PI_OUT : arnd;
      asig         = a_neg ? -asat : asat;
      out_angle_in = asig[ANGLE_W-1:0];
   end

   assign adv5     = !out_valid_ff || out_ready;
   assign adv4     = !s4_valid_ff || adv5;
   assign adv3     = !s3_valid_ff || adv4;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff  <= in_valid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) s3_valid_ff  <= s2_valid_ff;
         if (adv4) s4_valid_ff  <= s3_valid_ff;
         if (adv5) out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_r30_ff  <= s1_r30_in;
         s1_sq_ff   <= s1_sq_in;
         s1_rneg_ff <= s1_rneg_in;
         s1_side_ff <= in_side;
      end
      if (adv2 && s1_valid_ff) begin
         s2_p_ff    <= s2_p_in;
         s2_r30_ff  <= s1_r30_ff;
         s2_rneg_ff <= s1_rneg_ff;
         s2_side_ff <= s1_side_ff;
      end
      if (adv3 && s2_valid_ff) begin
         s3_prod_ff <= s3_prod_in;
         s3_rneg_ff <= s2_rneg_ff;
         s3_side_ff <= s2_side_ff;
      end
      if (adv4 && s3_valid_ff) begin
         s4_a_ff <= s4_a_in;
      end
      if (adv5 && s4_valid_ff) begin
         out_angle_ff <= out_angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = out_angle_ff;

   a_ratio_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_r30_ff <= (R30_W'(1) << QI))
      else $error("ratio magnitude above one");

   a_angle_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (PI_OUT >= A_W'(1 << (ANGLE_W - 1)))
         || (($signed(out_angle_ff) <= $signed(PI_OUT[ANGLE_W-1:0]))
         && ($signed(out_angle_ff) >= -$signed(PI_OUT[ANGLE_W-1:0]))))
      else $error("angle outside plus or minus pi");

endmodule

`default_nettype wire
